>>> rtl/piecewise_linear_curve_map_macros.svh
// Assertion macros used by the checker of the piecewise linear curve map.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef PIECEWISE_LINEAR_CURVE_MAP_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_MAP_MACROS_SVH

// Property sampled on the rising clock edge, switched off while reset is high.
`define PLCM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on the rising clock edge, also checked across reset.
`define PLCM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/plcm_pkg.sv
// Shared types and constants of the piecewise linear curve map.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package plcm_pkg;

   localparam int unsigned VALUE_W = 16;

   // Operation codes of the request channel.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // The restoring divider retires one quotient bit per cycle.
   localparam int unsigned DIV_STEPS = VALUE_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [DIV_CNT_W-1:0] div_cnt_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_point;   // store the request's point
      logic latch_level;   // capture the request's level
      logic advance;       // current point becomes segment start
      logic set_hit;       // level equals segment end: take its y
      logic set_miss;      // no segment covers the level
      logic capture;       // register offset, span, delta and direction
      logic mul;           // offset times delta into the divider
      logic div_step;      // one restoring division step
      logic finish;        // apply the quotient to the start y
      logic load_out;      // move the result into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic eq_hit;        // level equals current point's x
      logic in_range;      // segment start x <= level <= current x
      logic out_free;      // response register can take a result
   } status_type;

endpackage

`default_nettype wire

>>> rtl/piecewise_linear_curve_map.sv
// Piecewise linear curve map: top level joining controller and datapath.
// Depends on plcm_pkg, plcm_ctrl and plcm_datapath.
//
// Usage: a request with operation write stores one (x, y) curve point at
// point_index and gives no response. A request with operation lookup maps
// level through the curve and gives one response with mapped_value and
// found. The csr channel sets point_count and is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// Timing: a lookup scans one segment per cycle out of the point memory's
// registered read port, then runs a multiply step and the restoring
// divider. With fewer than two points used a lookup ends in a miss
// without a scan; otherwise it ends on a hit when the level sits on the
// end of a segment, and after the divider when it is interpolated.
// The request channel stalls while a lookup is in flight; a write never makes it stall.
// A result waits in the response register while the receiver stalls; new
// requests are still taken, and a later lookup holds in its last step until
// that register is free. Reset empties the response register, returns the
// controller to idle and sets point_count to 2; curve points keep no reset.
`default_nettype none

module piecewise_linear_curve_map
   import plcm_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_operation,
   input  wire logic [2:0]           req_point_index,
   input  wire logic [VALUE_W-1:0]   req_point_x,
   input  wire logic [VALUE_W-1:0]   req_point_y,
   input  wire logic [VALUE_W-1:0]   req_level,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [VALUE_W-1:0]        rsp_mapped_value,
   output logic                      rsp_found,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [3:0]           csr_point_count
);

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned KW = $clog2(MAX_POINTS + 1);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] used_count;
   logic          idle;

   // The block never refuses a register write.
   assign csr_ready = 1'b1;

   // Requests are taken only while the controller waits for work.
   assign req_stall = !idle;

   plcm_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .used_count    (used_count),
      .status        (status),
      .idle          (idle),
      .cmd           (cmd),
      .rd_addr       (rd_addr)
   );

   plcm_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .req_point_index  (req_point_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_level        (req_level),
      .csr_write        (csr_valid && csr_ready),
      .csr_point_count  (csr_point_count),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_found        (rsp_found),
      .used_count       (used_count),
      .status           (status)
   );

endmodule

`default_nettype wire

>>> rtl/plcm_ctrl.sv
// Controller of the curve map: sequences the segment scan and the divider.
// Depends on plcm_pkg; drives the datapath through cmd_type.
`default_nettype none

module plcm_ctrl
   import plcm_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_operation,
   input  wire logic [$clog2(MAX_POINTS+1)-1:0]   used_count,
   input  wire status_type                        status,
   output logic                                   idle,
   output cmd_type                                cmd,
   output logic [$clog2(MAX_POINTS)-1:0]          rd_addr
);

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned KW = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD0,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   div_cnt_type   cnt_ff, cnt_in;

   assign idle = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      rd_addr  = '0;
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_WRITE) begin
                  cmd.write_point = 1'b1;
               end else begin
                  cmd.latch_level = 1'b1;
                  if (used_count < KW'(2)) begin
                     cmd.set_miss = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     state_in = ST_LOAD0;
                  end
               end
            end
         end
         ST_LOAD0: begin
            cmd.advance = 1'b1;
            rd_addr     = AW'(1);
            k_in        = KW'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.eq_hit) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_DONE;
            end else if (status.in_range) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end else if ((k_ff + KW'(1)) == used_count) begin
               cmd.set_miss = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               rd_addr     = AW'(k_ff + KW'(1));
               k_in        = k_ff + KW'(1);
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + div_cnt_type'(1);
            if (cnt_ff == div_cnt_type'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/plcm_datapath.sv
// Datapath of the curve map: point memory, segment compare, multiplier,
// restoring divider and response register. Depends on plcm_pkg.
`default_nettype none

module plcm_datapath
   import plcm_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmd_type                           cmd,
   input  wire logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
   input  wire logic [2:0]                        req_point_index,
   input  wire logic [VALUE_W-1:0]                req_point_x,
   input  wire logic [VALUE_W-1:0]                req_point_y,
   input  wire logic [VALUE_W-1:0]                req_level,
   input  wire logic                              csr_write,
   input  wire logic [3:0]                        csr_point_count,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic [VALUE_W-1:0]                     rsp_mapped_value,
   output logic                                   rsp_found,
   output logic [$clog2(MAX_POINTS+1)-1:0]        used_count,
   output status_type                             status
);

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned KW = $clog2(MAX_POINTS + 1);

   // Each entry holds y in the upper half and x in the lower half.
   logic [2*VALUE_W-1:0] curve_mem_ff [MAX_POINTS];
   logic [2*VALUE_W-1:0] rd_data_ff;

   logic [3:0]           point_count_ff;
   logic [VALUE_W-1:0]   level_ff;
   logic [VALUE_W-1:0]   prev_x_ff, prev_y_ff;
   logic [VALUE_W-1:0]   off_ff, span_ff, delta_ff, base_y_ff;
   logic                 up_ff;
   logic [VALUE_W-1:0]   rem_ff, quo_ff;
   logic [VALUE_W-1:0]   res_value_ff;
   logic                 res_found_ff;
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_found_ff;

   logic [VALUE_W-1:0]   cur_x, cur_y;
   logic                 index_ok;
   logic [2*VALUE_W-1:0] product;
   logic [VALUE_W:0]     trial;
   logic                 trial_ge;
   logic [VALUE_W:0]     trial_diff;

   assign cur_x = rd_data_ff[VALUE_W-1:0];
   assign cur_y = rd_data_ff[2*VALUE_W-1:VALUE_W];

   assign index_ok   = (32'(req_point_index) < MAX_POINTS);
   assign used_count = (32'(point_count_ff) > MAX_POINTS) ? KW'(MAX_POINTS)
                                                          : KW'(point_count_ff);

   assign status.eq_hit   = (level_ff == cur_x);
   assign status.in_range = (prev_x_ff <= level_ff) && (level_ff <= cur_x);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign product = off_ff * delta_ff;

   // The partial remainder stays below the span, so one shifted-in bit
   // and a 17-bit compare decide each quotient bit.
   assign trial      = {rem_ff, quo_ff[VALUE_W-1]};
   assign trial_diff = trial - {1'b0, span_ff};
   assign trial_ge   = (trial >= {1'b0, span_ff});

   always_ff @(posedge clock) begin
      if (cmd.write_point && index_ok) begin
         curve_mem_ff[AW'(req_point_index)] <= {req_point_y, req_point_x};
      end
      rd_data_ff <= curve_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 4'd2;
      end else if (csr_write) begin
         point_count_ff <= csr_point_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_level) begin
         level_ff <= req_level;
      end
      if (cmd.advance) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      if (cmd.capture) begin
         off_ff    <= level_ff - prev_x_ff;
         span_ff   <= cur_x - prev_x_ff;
         base_y_ff <= prev_y_ff;
         up_ff     <= (cur_y > prev_y_ff);
         delta_ff  <= (cur_y > prev_y_ff) ? (cur_y - prev_y_ff) : (prev_y_ff - cur_y);
      end
      if (cmd.mul) begin
         rem_ff <= product[2*VALUE_W-1:VALUE_W];
         quo_ff <= product[VALUE_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
         quo_ff <= {quo_ff[VALUE_W-2:0], trial_ge};
      end
      if (cmd.set_hit) begin
         res_value_ff <= cur_y;
         res_found_ff <= 1'b1;
      end else if (cmd.set_miss) begin
         res_value_ff <= '0;
         res_found_ff <= 1'b0;
      end else if (cmd.finish) begin
         res_value_ff <= up_ff ? (base_y_ff + quo_ff) : (base_y_ff - quo_ff);
         res_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_value_ff <= res_value_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;

endmodule

`default_nettype wire

>>> rtl/plcm_checker.sv
// Port-level checker of the piecewise linear curve map and its bind.
// Depends on piecewise_linear_curve_map_macros.svh.
`default_nettype none
`include "piecewise_linear_curve_map_macros.svh"

module plcm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_operation,
   input wire logic [2:0]  req_point_index,
   input wire logic [15:0] req_point_x,
   input wire logic [15:0] req_point_y,
   input wire logic [15:0] req_level,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_mapped_value,
   input wire logic        rsp_found,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [3:0]  csr_point_count
);

   // A stalled response keeps its payload until the transfer.
   `PLCM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mapped_value) && $stable(rsp_found), "response changed while stalled")

   // A miss always reports the value zero.
   `PLCM_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_mapped_value == 16'd0, "miss with nonzero value")

   // A lookup occupies the block for at least the cycle after its transfer.
   `PLCM_ASSERT(a_lookup_busy, clock, reset, req_valid && !req_stall && req_operation |=> req_stall, "lookup did not stall requests")

   // Reset empties the response register and frees the request channel.
   `PLCM_ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `PLCM_ASSERT_ALWAYS(a_reset_req, clock, reset |=> !req_stall, "requests stalled after reset")

endmodule

bind piecewise_linear_curve_map plcm_checker u_plcm_checker (.*);

`default_nettype wire
